// ===== rtl/sbrfc_pkg.sv =====
// Shared types and codes for the serial bridge ring block.
`default_nettype none

package sbrfc_pkg;

    // Request codes carried in req_type
    typedef enum logic [2:0] {
        REQ_HOST = 3'd0,
        REQ_POP  = 3'd1,
        REQ_UART = 3'd2,
        REQ_SEND = 3'd3,
        REQ_DONE = 3'd4
    } req_kind_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] byte_in;
        logic       packet_end;
    } request_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       byte_valid;
        logic       last;
        logic       dropped;
        logic       out_rearm;
        logic       out_halted;
        logic       link_busy;
        logic [7:0] tx_fill;
        logic [7:0] rx_fill;
    } result_t;

    typedef enum logic {
        ST_IDLE,
        ST_BURST
    } ctl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;      // request taken this cycle
        logic launch;      // send request that moves data
        logic single;      // one-result request answered this cycle
        logic burst;       // a send byte is shown this cycle
        logic burst_more;  // more send bytes follow, fetch the next one
        logic burst_last;  // final send byte shown this cycle
    } ctl_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/serial_bridge_ring_flow_control.sv =====
// Top level: serial bridge with transmit/receive byte rings and OUT endpoint flow control.
// Every request gives its first result in the cycle after it is taken.
// Throughput: one request per cycle while busy is low; a send request moving up to PACKET_MAX
//   bytes shows them back to back and holds busy until its final byte is shown,
//   paced by the single registered read port of the receive ring RAM.
// Results cannot be stalled: each is on the ports for one cycle with strobe high.
// Reset (rst_n, async low) clears ring pointers, halt, busy and loopback; ring RAM is not cleared.
`default_nettype none

module serial_bridge_ring_flow_control #(
    parameter int RING_DEPTH = 256,   // power of two, 128..4096
    parameter int PACKET_MAX = 64     // 8..64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_data,
    input  wire logic                 start,
    output logic                      busy,
    input  wire sbrfc_pkg::request_t  request,
    output logic                      strobe,
    output sbrfc_pkg::result_t        result
);

    localparam int CW = $clog2(PACKET_MAX + 1);

    sbrfc_pkg::ctl_cmd_t cmd;
    logic                send_ok;
    logic [CW-1:0]       send_len;

    // Controller: takes a request whenever busy is low. A send request with data
    // starts a burst; the counter walks the bytes, and busy drops on the final
    // byte so the next request can overlap it.
    sbrfc_ctrl #(.PACKET_MAX(PACKET_MAX)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (request.req_type),
        .send_ok  (send_ok),
        .send_len (send_len),
        .busy     (busy),
        .cmd      (cmd)
    );

    // Datapath: all state updates land at the accept edge, so flags and fills on
    // the result ports already show the state after the request. Ring reads are
    // issued at the accept edge (first byte) and during the burst (the rest).
    sbrfc_dpath #(.RING_DEPTH(RING_DEPTH), .PACKET_MAX(PACKET_MAX)) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .request  (request),
        .cmd      (cmd),
        .send_ok  (send_ok),
        .send_len (send_len),
        .strobe   (strobe),
        .result   (result)
    );

endmodule

`default_nettype wire

// ===== rtl/sbrfc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sbrfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/sbrfc_ctrl.sv =====
// Controller: request acceptance and send burst sequencing.
`default_nettype none

module sbrfc_ctrl #(
    parameter int PACKET_MAX = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [2:0]                      req_type,
    input  wire logic                            send_ok,
    input  wire logic [$clog2(PACKET_MAX+1)-1:0] send_len,
    output logic                                 busy,
    output sbrfc_pkg::ctl_cmd_t                  cmd
);

    localparam int CW = $clog2(PACKET_MAX + 1);

    sbrfc_pkg::ctl_state_t state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  single_reg, single_next;
    logic                  accept, launch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sbrfc_pkg::ST_IDLE;
            count_reg  <= '0;
            single_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            single_reg <= single_next;
        end
    end

    always_comb
    begin
        busy   = (state_reg == sbrfc_pkg::ST_BURST) && (count_reg > CW'(1));
        accept = start && !busy;
        launch = accept && (req_type == sbrfc_pkg::REQ_SEND) && send_ok;
        single_next = accept && !launch;
        state_next  = state_reg;
        count_next  = count_reg;

        unique case (state_reg)
            sbrfc_pkg::ST_IDLE:
            begin
                if (launch)
                begin
                    state_next = sbrfc_pkg::ST_BURST;
                    count_next = send_len;
                end
            end
            sbrfc_pkg::ST_BURST:
            begin
                if (count_reg > CW'(1))
                begin
                    count_next = count_reg - CW'(1);
                end
                else if (launch)
                begin
                    count_next = send_len;
                end
                else
                begin
                    state_next = sbrfc_pkg::ST_IDLE;
                    count_next = '0;
                end
            end
            default:
            begin
                state_next = sbrfc_pkg::ST_IDLE;
            end
        endcase

        cmd.accept     = accept;
        cmd.launch     = launch;
        cmd.single     = single_reg;
        cmd.burst      = (state_reg == sbrfc_pkg::ST_BURST);
        cmd.burst_more = busy;
        cmd.burst_last = (state_reg == sbrfc_pkg::ST_BURST) && (count_reg == CW'(1));
    end

endmodule

`default_nettype wire

// ===== rtl/sbrfc_dpath.sv =====
// Datapath: both rings, pointers, flow and busy flags, result assembly.
`default_nettype none

module sbrfc_dpath #(
    parameter int RING_DEPTH = 256,
    parameter int PACKET_MAX = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic                            cfg_data,
    input  wire sbrfc_pkg::request_t             request,
    input  wire sbrfc_pkg::ctl_cmd_t             cmd,
    output logic                                 send_ok,
    output logic [$clog2(PACKET_MAX+1)-1:0]      send_len,
    output logic                                 strobe,
    output sbrfc_pkg::result_t                   result
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(PACKET_MAX + 1);
    localparam int EW = AW + 8;
    localparam logic [AW-1:0] THRESH = AW'(RING_DEPTH - PACKET_MAX);

    logic [AW-1:0] tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic [AW-1:0] rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic          busy_reg, busy_next, halt_reg, halt_next, loop_reg, loop_next;
    logic          drop_reg, drop_next, rearm_reg, rearm_next, popv_reg, popv_next;

    logic [AW-1:0] tx_fill, rx_fill, rx_raddr;
    logic          tx_full, rx_full, tx_we, rx_we;
    logic [7:0]    tx_q, rx_q;

    assign tx_fill  = tx_head_reg - tx_tail_reg;
    assign rx_fill  = rx_head_reg - rx_tail_reg;
    assign tx_full  = (tx_head_reg + AW'(1)) == tx_tail_reg;
    assign rx_full  = (rx_head_reg + AW'(1)) == rx_tail_reg;
    assign send_ok  = !busy_reg && (rx_fill != '0);
    assign send_len = (EW'(rx_fill) > EW'(PACKET_MAX)) ? CW'(PACKET_MAX) : CW'(rx_fill);
    assign rx_raddr = cmd.burst_more ? rd_ptr_reg : rx_tail_reg;

    sbrfc_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_head_reg),
        .wdata (request.byte_in),
        .raddr (tx_tail_reg),
        .rdata (tx_q)
    );

    sbrfc_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_head_reg),
        .wdata (request.byte_in),
        .raddr (rx_raddr),
        .rdata (rx_q)
    );

    always_comb
    begin
        logic [AW-1:0] post_fill;
        logic          full;

        tx_head_next = tx_head_reg;
        tx_tail_next = tx_tail_reg;
        rx_head_next = rx_head_reg;
        rx_tail_next = rx_tail_reg;
        rd_ptr_next  = rd_ptr_reg;
        busy_next    = busy_reg;
        halt_next    = halt_reg;
        loop_next    = cfg_we ? cfg_data : loop_reg;
        drop_next    = 1'b0;
        // re-arm of a send is held until its final byte is shown
        rearm_next   = cmd.burst_more ? rearm_reg : 1'b0;
        popv_next    = 1'b0;
        tx_we        = 1'b0;
        rx_we        = 1'b0;
        post_fill    = '0;
        full         = 1'b0;

        if (cmd.accept)
        begin
            unique case (request.req_type)
                sbrfc_pkg::REQ_HOST:
                begin
                    full      = loop_reg ? rx_full : tx_full;
                    drop_next = full;
                    if (loop_reg)
                    begin
                        rx_we        = !rx_full;
                        rx_head_next = rx_full ? rx_head_reg : rx_head_reg + AW'(1);
                        post_fill    = rx_full ? rx_fill : rx_fill + AW'(1);
                    end
                    else
                    begin
                        tx_we        = !tx_full;
                        tx_head_next = tx_full ? tx_head_reg : tx_head_reg + AW'(1);
                        post_fill    = tx_full ? tx_fill : tx_fill + AW'(1);
                    end
                    // end of host packet: halt or re-arm the OUT endpoint
                    if (request.packet_end)
                    begin
                        if (post_fill >= THRESH)
                        begin
                            halt_next = 1'b1;
                        end
                        else
                        begin
                            halt_next  = 1'b0;
                            rearm_next = 1'b1;
                        end
                    end
                end
                sbrfc_pkg::REQ_POP:
                begin
                    popv_next    = (tx_fill != '0);
                    tx_tail_next = popv_next ? tx_tail_reg + AW'(1) : tx_tail_reg;
                    post_fill    = popv_next ? tx_fill - AW'(1) : tx_fill;
                    if (!loop_reg && halt_reg && (post_fill < THRESH))
                    begin
                        halt_next  = 1'b0;
                        rearm_next = 1'b1;
                    end
                end
                sbrfc_pkg::REQ_UART:
                begin
                    drop_next    = rx_full;
                    rx_we        = !rx_full;
                    rx_head_next = rx_full ? rx_head_reg : rx_head_reg + AW'(1);
                end
                sbrfc_pkg::REQ_SEND:
                begin
                    if (cmd.launch)
                    begin
                        rx_tail_next = rx_tail_reg + AW'(send_len);
                        rd_ptr_next  = rx_tail_reg + AW'(1);
                        busy_next    = 1'b1;
                        post_fill    = rx_fill - AW'(send_len);
                        if (loop_reg && halt_reg && (post_fill < THRESH))
                        begin
                            halt_next  = 1'b0;
                            rearm_next = 1'b1;
                        end
                    end
                end
                sbrfc_pkg::REQ_DONE:
                begin
                    busy_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.burst_more)
        begin
            rd_ptr_next = rd_ptr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_head_reg <= '0;
            tx_tail_reg <= '0;
            rx_head_reg <= '0;
            rx_tail_reg <= '0;
            busy_reg    <= 1'b0;
            halt_reg    <= 1'b0;
            loop_reg    <= 1'b0;
        end
        else
        begin
            tx_head_reg <= tx_head_next;
            tx_tail_reg <= tx_tail_next;
            rx_head_reg <= rx_head_next;
            rx_tail_reg <= rx_tail_next;
            busy_reg    <= busy_next;
            halt_reg    <= halt_next;
            loop_reg    <= loop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        drop_reg   <= drop_next;
        rearm_reg  <= rearm_next;
        popv_reg   <= popv_next;
    end

    always_comb
    begin
        strobe            = cmd.single || cmd.burst;
        result.byte_out   = cmd.single ? (popv_reg ? tx_q : 8'h00) : rx_q;
        result.byte_valid = cmd.single ? popv_reg : 1'b1;
        result.last       = cmd.single || cmd.burst_last;
        result.dropped    = cmd.single && drop_reg;
        result.out_rearm  = (cmd.single || cmd.burst_last) && rearm_reg;
        result.out_halted = halt_reg;
        result.link_busy  = busy_reg;
        result.tx_fill    = (EW'(tx_fill) > EW'(255)) ? 8'hFF : 8'(tx_fill);
        result.rx_fill    = (EW'(rx_fill) > EW'(255)) ? 8'hFF : 8'(rx_fill);
    end

endmodule

`default_nettype wire

// ===== rtl/sbrfc_checker.sv =====
// Port-level checks for the serial bridge ring block, bound to the top level.
`default_nettype none

module sbrfc_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                strobe,
    input wire sbrfc_pkg::result_t  result
);

    // every taken request answers in the next cycle
    a_answer: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> strobe)
        else $error("accepted request gave no result next cycle");

    // busy only while a send burst is streaming
    a_busy_burst: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> strobe && !result.last)
        else $error("busy without a burst in progress");

    // a non-final result is followed by another result
    a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |=> strobe)
        else $error("burst broke off before its last byte");

    // fills and flags hold across one burst
    a_burst_stable: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |=> $stable(result.tx_fill) && $stable(result.rx_fill)
            && $stable(result.out_halted) && result.link_busy)
        else $error("state changed inside a burst");

endmodule

bind serial_bridge_ring_flow_control sbrfc_checker u_sbrfc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the serial bridge ring block: directed table, then random traffic.

module testbench;

    // Block configuration under test; the scoreboard model follows the same sizes.
    localparam int RING_DEPTH    = 256;
    localparam int PACKET_MAX    = 64;
    localparam int RING_MASK     = RING_DEPTH - 1;
    localparam int HALT_LEVEL    = RING_DEPTH - PACKET_MAX;  // OUT endpoint halt threshold
    localparam int STALL_LIMIT   = 1000;  // cycles with no request and no result taken
    localparam int SETTLE_CYCLES = 8;

    // Request codes the block must ignore
    localparam logic [2:0] REQ_RSV5 = 3'd5;
    localparam logic [2:0] REQ_RSV6 = 3'd6;
    localparam logic [2:0] REQ_RSV7 = 3'd7;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                cfg_we   = 1'b0;
    logic                cfg_data = 1'b0;
    logic                start    = 1'b0;
    logic                busy;
    sbrfc_pkg::request_t request  = '0;
    logic                strobe;
    sbrfc_pkg::result_t  result;

    // A hand-written expectation travels with the request it belongs to.
    logic                pin_use = 1'b0;
    sbrfc_pkg::result_t  pin_exp = '0;

    serial_bridge_ring_flow_control #(
        .RING_DEPTH(RING_DEPTH),
        .PACKET_MAX(PACKET_MAX)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .strobe   (strobe),
        .result   (result)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Scoreboard model of the bridge: both rings, halt and busy flags.
    // ------------------------------------------------------------------
    logic [7:0] tx_ring [RING_DEPTH];
    logic [7:0] rx_ring [RING_DEPTH];
    int         tx_wr = 0, tx_rd = 0, rx_wr = 0, rx_rd = 0;
    logic       halted_m   = 1'b0;
    logic       link_busy_m = 1'b0;
    logic       loopback_m = 1'b0;

    sbrfc_pkg::result_t step_out [$];          // results of the request just taken
    sbrfc_pkg::result_t pending_results [$];   // results still owed by the block
    int                 mismatches = 0;

    function automatic int ring_fill(input int wr, input int rd);
        return (wr - rd) & RING_MASK;
    endfunction

    // Returns 1 when the ring is full and the byte is thrown away.
    function automatic logic ring_push(input logic to_rx, input logic [7:0] b);
        if (to_rx) begin
            if (((rx_wr + 1) & RING_MASK) == rx_rd)
                return 1'b1;
            rx_ring[rx_wr] = b;
            rx_wr = (rx_wr + 1) & RING_MASK;
        end
        else begin
            if (((tx_wr + 1) & RING_MASK) == tx_rd)
                return 1'b1;
            tx_ring[tx_wr] = b;
            tx_wr = (tx_wr + 1) & RING_MASK;
        end
        return 1'b0;
    endfunction

    // Re-arm the endpoint once the fill is back under the threshold.
    function automatic logic release_check(input int level);
        if (halted_m && level < HALT_LEVEL) begin
            halted_m = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // One result word; flags and fills reflect the model state right now.
    function automatic sbrfc_pkg::result_t status(input logic [7:0] b, input logic valid,
                                                  input logic fin, input logic drop,
                                                  input logic rearm);
        sbrfc_pkg::result_t r;
        int                 tf, rf;
        tf = ring_fill(tx_wr, tx_rd);
        rf = ring_fill(rx_wr, rx_rd);
        r.byte_out   = b;
        r.byte_valid = valid;
        r.last       = fin;
        r.dropped    = drop;
        r.out_rearm  = rearm;
        r.out_halted = halted_m;
        r.link_busy  = link_busy_m;
        r.tx_fill    = (tf > 255) ? 8'hFF : 8'(tf);
        r.rx_fill    = (rf > 255) ? 8'hFF : 8'(rf);
        return r;
    endfunction

    task automatic bridge_step(input sbrfc_pkg::request_t r);
        logic       drop, rearm, valid;
        logic [7:0] v;
        logic [7:0] burst [$];
        int         level, n, i;
        drop  = 1'b0;
        rearm = 1'b0;
        step_out.delete();
        case (r.req_type)
            sbrfc_pkg::REQ_HOST: begin
                // host byte lands in the receive ring when looped back
                drop  = ring_push(loopback_m, r.byte_in);
                level = loopback_m ? ring_fill(rx_wr, rx_rd) : ring_fill(tx_wr, tx_rd);
                if (r.packet_end) begin
                    if (level >= HALT_LEVEL) begin
                        halted_m = 1'b1;
                    end
                    else begin
                        halted_m = 1'b0;
                        rearm    = 1'b1;
                    end
                end
                step_out.push_back(status(8'h00, 1'b0, 1'b1, drop, rearm));
            end
            sbrfc_pkg::REQ_POP: begin
                v     = 8'h00;
                valid = 1'b0;
                if (tx_wr != tx_rd) begin
                    v     = tx_ring[tx_rd];
                    tx_rd = (tx_rd + 1) & RING_MASK;
                    valid = 1'b1;
                end
                // in loopback the transmit ring is not the one that gates the endpoint
                if (!loopback_m)
                    rearm = release_check(ring_fill(tx_wr, tx_rd));
                step_out.push_back(status(v, valid, 1'b1, 1'b0, rearm));
            end
            sbrfc_pkg::REQ_UART: begin
                drop = ring_push(1'b1, r.byte_in);
                step_out.push_back(status(8'h00, 1'b0, 1'b1, drop, 1'b0));
            end
            sbrfc_pkg::REQ_SEND: begin
                n = ring_fill(rx_wr, rx_rd);
                if (link_busy_m || n == 0) begin
                    step_out.push_back(status(8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
                end
                else begin
                    if (n > PACKET_MAX)
                        n = PACKET_MAX;
                    repeat (n) begin
                        burst.push_back(rx_ring[rx_rd]);
                        rx_rd = (rx_rd + 1) & RING_MASK;
                    end
                    link_busy_m = 1'b1;
                    if (loopback_m)
                        rearm = release_check(ring_fill(rx_wr, rx_rd));
                    for (i = 0; i < n; i++)
                        step_out.push_back(status(burst[i], 1'b1, i == n - 1, 1'b0,
                                                  (i == n - 1) ? rearm : 1'b0));
                end
            end
            sbrfc_pkg::REQ_DONE: begin
                link_busy_m = 1'b0;
                step_out.push_back(status(8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
            end
            default: begin
                // unused codes: one empty result, no state change
                step_out.push_back(status(8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
            end
        endcase
    endtask

    function automatic string show(input sbrfc_pkg::result_t r);
        return $sformatf("byte=%h v=%b last=%b drop=%b rearm=%b halt=%b busy=%b tx=%0d rx=%0d",
                         r.byte_out, r.byte_valid, r.last, r.dropped, r.out_rearm,
                         r.out_halted, r.link_busy, r.tx_fill, r.rx_fill);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] ERROR: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Monitor: checks results, then books the request taken at this edge.
    // Everything is sampled at the rising edge, before the block updates.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        sbrfc_pkg::result_t want;
        string              diffs;
        if (!rst_n) begin
            tx_wr = 0;
            tx_rd = 0;
            rx_wr = 0;
            rx_rd = 0;
            halted_m    = 1'b0;
            link_busy_m = 1'b0;
            loopback_m  = 1'b0;
            pending_results.delete();
        end
        else begin
            if (strobe) begin
                if (pending_results.size() == 0) begin
                    report_mismatch({"result with nothing pending: ", show(result)});
                end
                else begin
                    want  = pending_results.pop_front();
                    diffs = "";
                    if (result.byte_out   !== want.byte_out)   diffs = {diffs, " byte_out"};
                    if (result.byte_valid !== want.byte_valid) diffs = {diffs, " byte_valid"};
                    if (result.last       !== want.last)       diffs = {diffs, " last"};
                    if (result.dropped    !== want.dropped)    diffs = {diffs, " dropped"};
                    if (result.out_rearm  !== want.out_rearm)  diffs = {diffs, " out_rearm"};
                    if (result.out_halted !== want.out_halted) diffs = {diffs, " out_halted"};
                    if (result.link_busy  !== want.link_busy)  diffs = {diffs, " link_busy"};
                    if (result.tx_fill    !== want.tx_fill)    diffs = {diffs, " tx_fill"};
                    if (result.rx_fill    !== want.rx_fill)    diffs = {diffs, " rx_fill"};
                    if (diffs != "")
                        report_mismatch($sformatf("mismatch on%s: got %s / want %s",
                                                  diffs, show(result), show(want)));
                end
            end
            if (cfg_we)
                loopback_m = cfg_data;
            if (start && !busy) begin
                bridge_step(request);
                // a typed row replaces the model's answer, the model state still advances
                if (pin_use)
                    pending_results.push_back(pin_exp);
                else
                    foreach (step_out[i])
                        pending_results.push_back(step_out[i]);
            end
        end
    end

    // Watchdog: any stretch with no request taken and no result shown is a hang.
    int stall_cycles = 0;
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || strobe) begin
            stall_cycles <= 0;
        end
        else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus side
    // ------------------------------------------------------------------
    typedef struct {
        sbrfc_pkg::request_t req;
        logic                typed;
        sbrfc_pkg::result_t  want;
    } stim_row_t;

    stim_row_t dir_rows [$];
    int        idle_pct = 0;   // chance of a sender gap before a request
    logic      lb_drv   = 1'b0;
    // Ring fills as the sender sees them; only pushes and pops move them, so the
    // sends in the directed table leave the receive estimate above the true fill.
    int        tx_est   = 0;
    int        rx_est   = 0;

    function automatic sbrfc_pkg::result_t res_of(input logic [7:0] b, input logic v,
                                                  input logic fin, input logic drop,
                                                  input logic rearm, input logic halt,
                                                  input logic bsy, input logic [7:0] tf,
                                                  input logic [7:0] rf);
        sbrfc_pkg::result_t r;
        r = '{b, v, fin, drop, rearm, halt, bsy, tf, rf};
        return r;
    endfunction

    task automatic add_row(input logic [2:0] kind, input logic [7:0] b, input logic pe,
                           input logic typed, input sbrfc_pkg::result_t want);
        stim_row_t row;
        row.req.req_type   = kind;
        row.req.byte_in    = b;
        row.req.packet_end = pe;
        row.typed          = typed;
        row.want           = want;
        dir_rows.push_back(row);
    endtask

    // Random payload for a given request kind.
    function automatic sbrfc_pkg::request_t any_req(input logic [2:0] kind);
        sbrfc_pkg::request_t r;
        r.req_type   = kind;
        r.byte_in    = 8'($urandom_range(0, 255));
        r.packet_end = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // Filler traffic; the quiet mix pushes nothing and never sends.
    function automatic sbrfc_pkg::request_t rand_req(input logic full_mix);
        int pick;
        pick = full_mix ? $urandom_range(0, 11) : $urandom_range(0, 5);
        case (pick)
            0, 1, 2: return any_req(sbrfc_pkg::REQ_POP);
            3, 4:    return any_req(sbrfc_pkg::REQ_DONE);
            5:       return any_req(3'($urandom_range(REQ_RSV5, REQ_RSV7)));
            6, 7:    return any_req(sbrfc_pkg::REQ_UART);
            8, 9:    return any_req(sbrfc_pkg::REQ_HOST);
            default: return any_req(sbrfc_pkg::REQ_SEND);
        endcase
    endfunction

    // Present one request and hold it until the block takes it.
    task automatic issue(input sbrfc_pkg::request_t r, input logic typed = 1'b0,
                         input sbrfc_pkg::result_t want = '0);
        int gap;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        pin_use <= typed;
        pin_exp <= want;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        case (r.req_type)
            sbrfc_pkg::REQ_HOST: begin
                if (lb_drv)
                    rx_est = (rx_est < RING_DEPTH - 1) ? rx_est + 1 : rx_est;
                else
                    tx_est = (tx_est < RING_DEPTH - 1) ? tx_est + 1 : tx_est;
            end
            sbrfc_pkg::REQ_POP:  tx_est = (tx_est > 0) ? tx_est - 1 : 0;
            sbrfc_pkg::REQ_UART: rx_est = (rx_est < RING_DEPTH - 1) ? rx_est + 1 : rx_est;
            default:  ;
        endcase
    endtask

    // Host packet: random bytes, packet_end on the final one.
    task automatic host_packet(input int len);
        sbrfc_pkg::request_t r;
        int                  k;
        for (k = 0; k < len; k++) begin
            r.req_type   = sbrfc_pkg::REQ_HOST;
            r.byte_in    = 8'($urandom_range(0, 255));
            r.packet_end = (k == len - 1);
            issue(r);
        end
    endtask

    // Stop sending and wait for every owed result. Returns on a rising edge.
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // The mode register is only touched with the block idle.
    task automatic cfg_write(input logic lb);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= lb;
        @(posedge clk);
        cfg_we   <= 1'b0;
        lb_drv   = lb;
    endtask

    initial begin
        int len;

        // Directed table. Typed rows are the plain cases; the send bursts and a
        // few others are left to the model.
        add_row(sbrfc_pkg::REQ_POP,  8'h00, 1'b0, 1'b1,
                res_of(8'h00, 0, 1, 0, 0, 0, 0, 8'd0, 8'd0));
        add_row(sbrfc_pkg::REQ_SEND, 8'h00, 1'b0, 1'b1,
                res_of(8'h00, 0, 1, 0, 0, 0, 0, 8'd0, 8'd0));
        add_row(sbrfc_pkg::REQ_DONE, 8'hFF, 1'b1, 1'b1,
                res_of(8'h00, 0, 1, 0, 0, 0, 0, 8'd0, 8'd0));
        add_row(REQ_RSV5, 8'hFF, 1'b1, 1'b1, res_of(8'h00, 0, 1, 0, 0, 0, 0, 8'd0, 8'd0));
        add_row(REQ_RSV6, 8'h00, 1'b0, 1'b1, res_of(8'h00, 0, 1, 0, 0, 0, 0, 8'd0, 8'd0));
        add_row(REQ_RSV7, 8'hA5, 1'b1, 1'b1, res_of(8'h00, 0, 1, 0, 0, 0, 0, 8'd0, 8'd0));
        add_row(sbrfc_pkg::REQ_HOST, 8'hFF, 1'b0, 1'b1,
                res_of(8'h00, 0, 1, 0, 0, 0, 0, 8'd1, 8'd0));
        // packet end well under the threshold re-arms
        add_row(sbrfc_pkg::REQ_HOST, 8'h00, 1'b1, 1'b1,
                res_of(8'h00, 0, 1, 0, 1, 0, 0, 8'd2, 8'd0));
        add_row(sbrfc_pkg::REQ_HOST, 8'h80, 1'b0, 1'b1,
                res_of(8'h00, 0, 1, 0, 0, 0, 0, 8'd3, 8'd0));
        add_row(sbrfc_pkg::REQ_POP,  8'h00, 1'b0, 1'b1,
                res_of(8'hFF, 1, 1, 0, 0, 0, 0, 8'd2, 8'd0));
        add_row(sbrfc_pkg::REQ_POP,  8'hFF, 1'b1, 1'b0, '0);
        add_row(sbrfc_pkg::REQ_UART, 8'hFF, 1'b0, 1'b1,
                res_of(8'h00, 0, 1, 0, 0, 0, 0, 8'd1, 8'd1));
        add_row(sbrfc_pkg::REQ_UART, 8'h01, 1'b1, 1'b1,
                res_of(8'h00, 0, 1, 0, 0, 0, 0, 8'd1, 8'd2));
        add_row(sbrfc_pkg::REQ_UART, 8'h00, 1'b0, 1'b0, '0);
        add_row(sbrfc_pkg::REQ_SEND, 8'h00, 1'b0, 1'b0, '0);   // three-byte burst
        add_row(sbrfc_pkg::REQ_UART, 8'h7E, 1'b0, 1'b1,
                res_of(8'h00, 0, 1, 0, 0, 0, 1, 8'd1, 8'd1));
        // send while the link is busy moves nothing
        add_row(sbrfc_pkg::REQ_SEND, 8'h00, 1'b0, 1'b1,
                res_of(8'h00, 0, 1, 0, 0, 0, 1, 8'd1, 8'd1));
        add_row(sbrfc_pkg::REQ_DONE, 8'h00, 1'b0, 1'b1,
                res_of(8'h00, 0, 1, 0, 0, 0, 0, 8'd1, 8'd1));
        add_row(sbrfc_pkg::REQ_SEND, 8'hFF, 1'b1, 1'b0, '0);   // single-byte burst
        add_row(sbrfc_pkg::REQ_DONE, 8'h00, 1'b0, 1'b1,
                res_of(8'h00, 0, 1, 0, 0, 0, 0, 8'd1, 8'd0));
        add_row(sbrfc_pkg::REQ_POP,  8'h00, 1'b0, 1'b1,
                res_of(8'h80, 1, 1, 0, 0, 0, 0, 8'd0, 8'd0));
        add_row(sbrfc_pkg::REQ_POP,  8'h00, 1'b0, 1'b1,
                res_of(8'h00, 0, 1, 0, 0, 0, 0, 8'd0, 8'd0));
        add_row(sbrfc_pkg::REQ_HOST, 8'h55, 1'b1, 1'b0, '0);

        // Reset is applied once.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cfg_write(1'b0);
        idle_pct = 25;
        foreach (dir_rows[i])
            issue(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

        // Normal mode: host packets walk the transmit ring past the halt level
        // while UART bytes build up the receive ring for later. Packet ends at
        // or above the threshold halt the endpoint; bytes keep coming anyway.
        while (tx_est < HALT_LEVEL + 8) begin
            idle_pct = ($urandom_range(0, 1) == 1) ? 30 : 0;
            len = $urandom_range(8, PACKET_MAX);
            if (len > HALT_LEVEL + 16 - tx_est)
                len = HALT_LEVEL + 16 - tx_est;
            host_packet(len);
            repeat ($urandom_range(len / 4, len / 2))
                issue(any_req(sbrfc_pkg::REQ_UART));
            if ($urandom_range(0, 2) == 0)
                issue(rand_req(1'b0));
        end

        // UART side drains the transmit ring; crossing below the threshold on a
        // pop re-arms the endpoint.
        while (tx_est >= HALT_LEVEL - 8) begin
            issue(any_req(sbrfc_pkg::REQ_POP));
            if ($urandom_range(0, 3) == 0)
                issue(any_req(sbrfc_pkg::REQ_UART));
        end

        // Loopback: host bytes now fill the receive ring until it overflows.
        cfg_write(1'b1);
        while (rx_est < RING_DEPTH - 1) begin
            idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
            len = $urandom_range(8, PACKET_MAX);
            if (len > RING_DEPTH + 15 - rx_est)
                len = RING_DEPTH + 15 - rx_est;
            host_packet(len);
            if ($urandom_range(0, 3) == 0)
                issue(rand_req(1'b0));
        end
        host_packet(8);                     // ring full: bytes dropped, stays halted
        repeat (3) issue(any_req(sbrfc_pkg::REQ_UART));
        repeat (3) issue(any_req(sbrfc_pkg::REQ_POP)); // pops do not re-arm in loopback
        issue(any_req(sbrfc_pkg::REQ_SEND)); // full packet out, fill drops under threshold
        drain();                            // sender holds off for the whole burst
        issue(any_req(sbrfc_pkg::REQ_DONE));
        repeat (10) begin
            if ($urandom_range(0, 3) == 0)
                host_packet($urandom_range(1, 12));
            else
                issue(rand_req(1'b1));
        end

        // Back to normal mode; the closing stretch runs without sender gaps.
        cfg_write(1'b0);
        idle_pct = 0;
        repeat (14) begin
            if ($urandom_range(0, 5) == 0)
                host_packet($urandom_range(1, 8));
            else
                issue(rand_req(1'b1));
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
